// File: hw/rtl/c3bcd_pkg.sv
// Shared types and constants for the 3x3 convolution block.
// No dependencies; imported by conv3x3_border_copy_divide and its testbench.
`default_nettype none

package c3bcd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WCFG_W     = 11;
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int KROW_W     = 24;
    localparam int DIV_W      = 12;
    localparam int ACC_W      = 20;
    localparam int MAG_W      = 19;
    localparam int CNT_W      = 5;
    localparam int DIV_STEPS  = MAG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int KSIZE      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_K_TOP    = 3'd2,
        CFG_K_MIDDLE = 3'd3,
        CFG_K_BOTTOM = 3'd4,
        CFG_DIVISOR  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/conv3x3_border_copy_divide.sv
// 3x3 convolution over a raster pixel stream with border copy and signed divide.
// Depends on c3bcd_pkg.
//
// Usage: pixels enter on in_valid/in_ready in raster order, one request each.
// Results leave on out_valid/out_ready with row, column, last_of_run and
// image_done; configuration enters on cfg_valid/cfg_ready (cfg_index, cfg_data).
// Each input reads both line stores, then shifts the window and writes back in
// ST_READ. An input in row 0 or column 0 then returns to idle and gives nothing.
// Any other input steps through ST_MAC (one multiply-accumulate per tap, 9 taps),
// ST_PREP, ST_DIV (bit-serial divider, 19 quotient bits) when the divisor is
// nonzero, and ST_EMIT for its 1, 2 or 4 results. One input is in work at a time.
// The output register lets a new input enter while the last result waits.
// When out_ready is low the block holds its result and stalls once the next is due.
// Reset clears counters, window and registers (width and height 512, kernel
// and divisor zero); line stores are not cleared and need no clearing pass.
`default_nettype none

module conv3x3_border_copy_divide (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [c3bcd_pkg::PIX_W-1:0]     pixel_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [c3bcd_pkg::PIX_W-1:0]          pixel_out,
    output logic [c3bcd_pkg::ROW_W-1:0]          out_row,
    output logic [c3bcd_pkg::COL_W-1:0]          out_col,
    output logic                                 last_of_run,
    output logic                                 image_done,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [c3bcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [c3bcd_pkg::KROW_W-1:0]    cfg_data
);
    import c3bcd_pkg::*;

    state_t                  state_reg, state_next;

    logic [WCFG_W-1:0]       width_reg;
    logic [ROW_W-1:0]        height_reg;
    logic [KROW_W-1:0]       kernel_reg [KSIZE];
    logic signed [DIV_W-1:0] divisor_reg;

    logic [PIX_W-1:0]        upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]        lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0]        rd_upper_reg, rd_lower_reg;
    logic [PIX_W-1:0]        pix_reg;
    logic [PIX_W-1:0]        win_reg [KSIZE][KSIZE];

    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        cur_row_reg;
    logic [COL_W-1:0]        cur_col_reg;
    logic                    last_row_reg, last_col_reg;

    logic [1:0]              mac_i_reg, mac_j_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [MAG_W-1:0]        quo_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        dmag_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic [PIX_W-1:0]        filt_reg;
    logic                    xi_reg, yi_reg;

    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_out_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic                    last_reg, done_reg;

    // control decoded from state
    logic                    accept, mem_we, emit_load;

    logic [WCFG_W-1:0]       w_eff, w_m1;
    logic [ROW_W-1:0]        h_eff, h_m1;
    logic                    last_col, last_row;
    logic                    mac_last;
    logic signed [PIX_W-1:0] coef;
    logic signed [PIX_W:0]   tap;
    logic signed [2*PIX_W:0] prod;
    logic signed [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0]        acc_neg;
    logic [DIV_W:0]          trial;
    logic                    trial_ge;
    logic [MAG_W-1:0]        quo_next;
    logic [PIX_W-1:0]        quo_low;
    logic [ROW_W-1:0]        emit_x;
    logic [COL_W-1:0]        emit_y;
    logic                    emit_border, emit_last;
    logic [PIX_W-1:0]        emit_val;

    // effective image size and end-of-line flags
    always_comb
    begin
        if (width_reg < WCFG_W'(3))
            w_eff = WCFG_W'(3);
        else if (width_reg > WCFG_W'(MAX_WIDTH))
            w_eff = WCFG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff    = (height_reg < ROW_W'(3)) ? ROW_W'(3) : height_reg;
        w_m1     = w_eff - WCFG_W'(1);
        h_m1     = h_eff - ROW_W'(1);
        last_col = WCFG_W'(col_reg) >= w_m1;
        last_row = row_reg >= h_m1;
    end

    // multiply-accumulate tap
    always_comb
    begin
        coef     = $signed(kernel_reg[mac_i_reg][{mac_j_reg, 3'b000} +: PIX_W]);
        tap      = $signed({1'b0, win_reg[mac_i_reg][mac_j_reg]});
        prod     = tap * coef;
        acc_next = acc_reg + {{(ACC_W-2*PIX_W-1){prod[2*PIX_W]}}, prod};
        mac_last = (mac_i_reg == 2'd2) && (mac_j_reg == 2'd2);
        acc_neg  = -acc_reg;
    end

    // restoring divide step on magnitudes
    always_comb
    begin
        trial    = {rem_reg, quo_reg[MAG_W-1]};
        trial_ge = trial >= {1'b0, dmag_reg};
        quo_next = {quo_reg[MAG_W-2:0], trial_ge};
        quo_low  = neg_reg ? (PIX_W'(0) - quo_next[PIX_W-1:0]) : quo_next[PIX_W-1:0];
    end

    // result selection
    always_comb
    begin
        emit_x      = cur_row_reg - ROW_W'(1) + ROW_W'(xi_reg);
        emit_y      = cur_col_reg - COL_W'(1) + COL_W'(yi_reg);
        emit_border = (emit_x == '0) || (emit_x >= h_m1) ||
                      (emit_y == '0) || (WCFG_W'(emit_y) >= w_m1);
        emit_last   = (xi_reg == last_row_reg) && (yi_reg == last_col_reg);
        emit_val    = emit_border ? win_reg[{xi_reg, ~xi_reg}][{yi_reg, ~yi_reg}]
                                  : filt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_READ;
            ST_READ:
                if (row_reg != '0 && col_reg != '0)
                    state_next = ST_MAC;
                else
                    state_next = ST_IDLE;
            ST_MAC:
                if (mac_last)
                    state_next = ST_PREP;
            ST_PREP:
                if (divisor_reg != '0)
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            ST_DIV:
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_EMIT;
            ST_EMIT:
                if ((!out_valid_reg || out_ready) && emit_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid && (state_reg == ST_IDLE);
        mem_we    = (state_reg == ST_READ);
        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        cfg_ready = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WCFG_W'(512);
            height_reg  <= ROW_W'(512);
            for (int i = 0; i < KSIZE; i++)
                kernel_reg[i] <= '0;
            divisor_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDTH:    width_reg     <= cfg_data[WCFG_W-1:0];
                CFG_HEIGHT:   height_reg    <= cfg_data[ROW_W-1:0];
                CFG_K_TOP:    kernel_reg[0] <= cfg_data;
                CFG_K_MIDDLE: kernel_reg[1] <= cfg_data;
                CFG_K_BOTTOM: kernel_reg[2] <= cfg_data;
                CFG_DIVISOR:  divisor_reg   <= $signed(cfg_data[DIV_W-1:0]);
                default:      ;
            endcase
        end
    end

    // line stores: read on accept, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_upper_reg <= upper_mem[col_reg];
            rd_lower_reg <= lower_mem[col_reg];
        end
        if (mem_we)
        begin
            upper_mem[cur_col_reg] <= rd_lower_reg;
            lower_mem[cur_col_reg] <= pix_reg;
        end
    end

    // window, counters and request context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KSIZE; i++)
                for (int j = 0; j < KSIZE; j++)
                    win_reg[i][j] <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            last_row_reg <= 1'b0;
            last_col_reg <= 1'b0;
        end
        else if (mem_we)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_upper_reg;
            win_reg[1][2] <= rd_lower_reg;
            win_reg[2][2] <= pix_reg;
            last_row_reg  <= last_row;
            last_col_reg  <= last_col;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg     <= pixel_in;
            cur_row_reg <= row_reg;
            cur_col_reg <= col_reg;
        end
    end

    // filter arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_i_reg   <= '0;
            mac_j_reg   <= '0;
            div_cnt_reg <= '0;
            xi_reg      <= 1'b0;
            yi_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_READ:
                begin
                    mac_i_reg <= '0;
                    mac_j_reg <= '0;
                    xi_reg    <= 1'b0;
                    yi_reg    <= 1'b0;
                end
                ST_MAC:
                begin
                    if (mac_j_reg == 2'd2)
                    begin
                        mac_j_reg <= '0;
                        mac_i_reg <= mac_i_reg + 2'd1;
                    end
                    else
                    begin
                        mac_j_reg <= mac_j_reg + 2'd1;
                    end
                end
                ST_PREP:
                    div_cnt_reg <= '0;
                ST_DIV:
                    div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                ST_EMIT:
                    if (emit_load)
                    begin
                        if (yi_reg != last_col_reg)
                        begin
                            yi_reg <= 1'b1;
                        end
                        else
                        begin
                            yi_reg <= 1'b0;
                            xi_reg <= 1'b1;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_READ:
                acc_reg <= '0;
            ST_MAC:
                acc_reg <= acc_next;
            ST_PREP:
            begin
                quo_reg  <= acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
                rem_reg  <= '0;
                dmag_reg <= divisor_reg[DIV_W-1] ? (DIV_W'(0) - divisor_reg)
                                                 : divisor_reg;
                neg_reg  <= acc_reg[ACC_W-1] ^ divisor_reg[DIV_W-1];
                filt_reg <= acc_reg[PIX_W-1:0];
            end
            ST_DIV:
            begin
                quo_reg <= quo_next;
                rem_reg <= trial_ge ? DIV_W'(trial - {1'b0, dmag_reg}) : DIV_W'(trial);
                if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                    filt_reg <= quo_low;
            end
            default:
                ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            pixel_out_reg <= emit_val;
            out_row_reg   <= emit_x;
            out_col_reg   <= emit_y;
            last_reg      <= emit_last;
            done_reg      <= emit_last && last_row_reg && last_col_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last_of_run = last_reg;
    assign image_done  = done_reg;

endmodule

`default_nettype wire

// File: tb/conv3x3_border_copy_divide_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_border_copy_divide: random pixel streams over many
// image sizes, kernels and divisors, checked against an in-bench model of the filter.
// Depends on c3bcd_pkg and the conv3x3_border_copy_divide RTL.

module conv3x3_border_copy_divide_tb;

    import c3bcd_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 64;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_TARGET  = 420;
    localparam int QUIET_TAIL     = 80;
    localparam int LIMIT_CYCLES   = 2000000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } conv_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel_in    = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     out_col;
    logic                 last_of_run;
    logic                 image_done;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [KROW_W-1:0]    cfg_data    = '0;

    // filter model state
    logic [WCFG_W-1:0] width_cfg;
    logic [ROW_W-1:0]  height_cfg;
    logic [KROW_W-1:0] kernel_rows [0:KSIZE-1];
    int                divisor_val;
    logic [PIX_W-1:0]  upper_line [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]  lower_line [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]  win [0:KSIZE-1][0:KSIZE-1];
    int                row_cnt;
    int                col_cnt;

    logic [PIX_W-1:0] source_pixels [$];
    conv_result_t     expected_pixels [$];

    bit idle_bursts     = 1'b1;
    int send_gap        = 0;
    int recv_gap        = 0;
    int stall_left      = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int mismatches      = 0;
    int accepted_pixels = 0;
    int checked_results = 0;
    int finished_images = 0;
    int cycles          = 0;

    conv3x3_border_copy_divide i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .image_done  (image_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int eff_width();
        int w;
        w = width_cfg;
        if (w < KSIZE) w = KSIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_cfg;
        if (h < KSIZE) h = KSIZE;
        return h;
    endfunction

    function automatic int pixels_to_image_end();
        int w;
        int h;
        int rem;
        w = eff_width();
        h = eff_height();
        rem = (col_cnt >= w - 1) ? 1 : w - col_cnt;
        if (row_cnt < h - 1) rem += (h - 1 - row_cnt) * w;
        return rem;
    endfunction

    function automatic logic [PIX_W-1:0] kernel_sum_pixel();
        int s;
        s = 0;
        for (int i = 0; i < KSIZE; i++)
            for (int j = 0; j < KSIZE; j++)
                s += int'(win[i][j]) * int'($signed(kernel_rows[i][8*j +: 8]));
        if (divisor_val != 0) s = s / divisor_val;
        return s[PIX_W-1:0];
    endfunction

    task automatic convolve_pixel(input logic [PIX_W-1:0] p);
        int           w;
        int           h;
        int           r;
        int           c;
        int           idx;
        int           nx;
        int           ny;
        int           x;
        int           y;
        bit           last_c;
        bit           last_r;
        bit           border;
        conv_result_t res;
        w = eff_width();
        h = eff_height();
        r = row_cnt;
        c = col_cnt;
        last_c = c >= w - 1;
        last_r = r >= h - 1;
        idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        for (int i = 0; i < KSIZE; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[idx];
        win[1][2] = lower_line[idx];
        win[2][2] = p;
        upper_line[idx] = lower_line[idx];
        lower_line[idx] = p;
        if (r >= 1 && c >= 1)
        begin
            nx = last_r ? 2 : 1;
            ny = last_c ? 2 : 1;
            for (int xi = 0; xi < nx; xi++)
            begin
                for (int yi = 0; yi < ny; yi++)
                begin
                    x = r - 1 + xi;
                    y = c - 1 + yi;
                    border = x == 0 || x >= h - 1 || y == 0 || y >= w - 1;
                    res.pix  = border ? win[1 + xi][1 + yi] : kernel_sum_pixel();
                    res.row  = ROW_W'(x);
                    res.col  = COL_W'(y);
                    res.last = (xi == nx - 1) && (yi == ny - 1);
                    res.done = res.last && last_r && last_c;
                    expected_pixels.push_back(res);
                end
            end
        end
        if (last_c)
        begin
            col_cnt = 0;
            row_cnt = last_r ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    task automatic check_output();
        conv_result_t want;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Unexpected output: pix %0d row %0d col %0d last %0b done %0b",
                         pixel_out, out_row, out_col, last_of_run, image_done);
        end
        else
        begin
            want = expected_pixels.pop_front();
            checked_results++;
            if (image_done === 1'b1) finished_images++;
            if (pixel_out !== want.pix || out_row !== want.row || out_col !== want.col ||
                last_of_run !== want.last || image_done !== want.done)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"Mismatch: expected pix %0d row %0d col %0d last %0b done %0b,",
                              " got pix %0d row %0d col %0d last %0b done %0b"},
                             want.pix, want.row, want.col, want.last, want.done,
                             pixel_out, out_row, out_col, last_of_run, image_done);
            end
        end
    endtask

    // caller stands at a rising edge and is left at one
    task automatic write_reg(input cfg_idx_t idx, input logic [KROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:    width_cfg = data[WCFG_W-1:0];
            CFG_HEIGHT:   height_cfg = data[ROW_W-1:0];
            CFG_K_TOP:    kernel_rows[0] = data;
            CFG_K_MIDDLE: kernel_rows[1] = data;
            CFG_K_BOTTOM: kernel_rows[2] = data;
            CFG_DIVISOR:  divisor_val = int'($signed(data[DIV_W-1:0]));
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // sample on the falling edge, once every driven value has settled
    task automatic wait_until_drained();
        do @(negedge clk);
        while (source_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KROW_W-1:0] pick_kernel();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h808080;
            3:       return 24'h7F7F7F;
            default: return KROW_W'($urandom());
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] pick_divisor();
        logic [KROW_W-1:0] junk;
        junk = KROW_W'($urandom()) & 24'hFFF000;
        case ($urandom_range(0, 6))
            0:       return junk | 24'h000;
            1:       return junk | 24'h001;
            2:       return junk | 24'hFFF;
            3:       return junk | 24'h7FF;
            4:       return junk | 24'h800;
            5:       return junk | KROW_W'($urandom_range(1, 16));
            default: return KROW_W'($urandom());
        endcase
    endfunction

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++) source_pixels.push_back(pick_pixel());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_in <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                convolve_pixel(pixel_in);
                accepted_pixels++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap == 0 && idle_bursts && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 16);
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (source_pixels.size() > 0)
                begin
                    in_valid <= 1'b1;
                    pixel_in <= source_pixels.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready) check_output();
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (recv_gap == 0 && idle_bursts && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 16);
                if (recv_gap > 0)
                begin
                    recv_gap--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int  n;
        int  img_w;
        int  img_h;
        int  random_pixels;
        bit  first_phase;
        bit  long_hold_done;
        logic [PIX_W-1:0] pattern [0:8];

        width_cfg   = WCFG_W'(512);
        height_cfg  = ROW_W'(512);
        divisor_val = 0;
        row_cnt     = 0;
        col_cnt     = 0;
        for (int i = 0; i < KSIZE; i++) kernel_rows[i] = '0;
        for (int i = 0; i < KSIZE; i++)
            for (int j = 0; j < KSIZE; j++) win[i][j] = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start on reset sizes and zero kernel, then shrink mid-row and end the image
        source_pixels.push_back(8'h00);
        source_pixels.push_back(8'hFF);
        push_pixels(3);
        wait_until_drained();
        write_reg(CFG_WIDTH, 24'd5);
        write_reg(CFG_HEIGHT, 24'd2);
        push_pixels(pixels_to_image_end());
        wait_until_drained();

        // undersized registers clamp to 3x3; extreme kernel bytes, divide by minus one
        write_reg(CFG_WIDTH, (KROW_W'($urandom()) & 24'hFFF800) | 24'd1);
        write_reg(CFG_HEIGHT, KROW_W'($urandom()) & 24'hFF0000);
        write_reg(CFG_K_TOP, 24'h80807F);
        write_reg(CFG_K_MIDDLE, 24'h7F8080);
        write_reg(CFG_K_BOTTOM, 24'hFF0180);
        write_reg(CFG_DIVISOR, 24'h000FFF);
        pattern = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        for (int i = 0; i < 9; i++) source_pixels.push_back(pattern[i]);
        wait_until_drained();

        // tallest height register, cut short partway down the image
        write_reg(CFG_WIDTH, 24'd3);
        write_reg(CFG_HEIGHT, 24'h00FFFF);
        write_reg(CFG_DIVISOR, 24'h0007FF);
        push_pixels(12);
        wait_until_drained();
        write_reg(CFG_HEIGHT, 24'd4);
        write_reg(CFG_DIVISOR, 24'h000800);
        push_pixels(pixels_to_image_end());
        wait_until_drained();

        // width above the maximum: start a wide row, then narrow it and end the image
        write_reg(CFG_WIDTH, 24'h0007FF);
        write_reg(CFG_HEIGHT, 24'd1);
        write_reg(CFG_K_TOP, pick_kernel());
        write_reg(CFG_K_MIDDLE, pick_kernel());
        write_reg(CFG_K_BOTTOM, pick_kernel());
        write_reg(CFG_DIVISOR, pick_divisor());
        push_pixels(6);
        wait_until_drained();
        write_reg(CFG_WIDTH, 24'd3);
        push_pixels(pixels_to_image_end());
        wait_until_drained();

        random_pixels  = 0;
        first_phase    = 1'b1;
        long_hold_done = 1'b0;
        while (random_pixels < RANDOM_TARGET)
        begin
            if (random_pixels >= RANDOM_TARGET - QUIET_TAIL) idle_bursts = 1'b0;
            img_w = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 10);
            img_h = $urandom_range(3, 8);
            write_reg(CFG_WIDTH, (KROW_W'($urandom()) & 24'hFFF800) | KROW_W'(img_w));
            write_reg(CFG_HEIGHT, (KROW_W'($urandom()) & 24'hFF0000) | KROW_W'(img_h));
            for (int k = 0; k < KSIZE; k++)
                if (first_phase || $urandom_range(0, 1) == 1)
                    write_reg(cfg_idx_t'(CFG_K_TOP + k), pick_kernel());
            write_reg(CFG_DIVISOR, pick_divisor());
            first_phase = 1'b0;
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, img_w * img_h - 1);
                push_pixels(n);
                random_pixels += n;
                wait_until_drained();
                write_reg(CFG_WIDTH, KROW_W'($urandom_range(3, img_w)));
                write_reg(CFG_HEIGHT, KROW_W'($urandom_range(3, 8)));
                write_reg(CFG_DIVISOR, pick_divisor());
            end
            n = pixels_to_image_end();
            push_pixels(n);
            random_pixels += n;
            if (!long_hold_done && random_pixels > RANDOM_TARGET / 3)
            begin
                // hold the output side while pixels keep arriving
                @(posedge clk);
                hold_requests <= hold_requests + 1;
                long_hold_done = 1'b1;
            end
            wait_until_drained();
        end

        $display("Run: %0d pixels in, %0d results checked, %0d images, %0d mismatches",
                 accepted_pixels, checked_results, finished_images, mismatches);
        $display("Covered border copy, clamped and resized images, kernel and divisor");
        $display("extremes, idle bursts on both sides and a long output stall");
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
